[hdl/oli_pkg.sv]
// ----------------------------------------------------------------------------
// oli_pkg
// Shared constants and types for the ordered list block: the list depth,
// the derived widths, and the command word that steers the row of cells.
// ----------------------------------------------------------------------------
package oli_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int POS_W  = 16;
    localparam int OP_W   = 2;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE     = 2'd2;

    // What every cell does at a clock edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_APPEND,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         pos;
        logic [CNT_W-1:0]         count;
    } cell_ctrl_t;

endpackage

[hdl/oli_cell.sv]
// ----------------------------------------------------------------------------
// oli_cell
// One list slot. Each cycle it keeps its value or takes it from the left
// neighbor, the right neighbor, the new value or the list head, as the
// broadcast command and its own place in the row decide.
// ----------------------------------------------------------------------------
module oli_cell (
    input  logic                              aclk,
    input  logic [oli_pkg::IDX_W-1:0]         cell_index,
    input  oli_pkg::cell_ctrl_t               ctrl,
    input  logic signed [oli_pkg::VAL_W-1:0]  left_data,
    input  logic signed [oli_pkg::VAL_W-1:0]  right_data,
    input  logic signed [oli_pkg::VAL_W-1:0]  head_data,
    output logic signed [oli_pkg::VAL_W-1:0]  cell_data
);
    import oli_pkg::*;

    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;
    logic [POS_W-1:0]        index_pos;
    logic [CNT_W-1:0]        index_plus1;
    logic [CNT_W-1:0]        index_cnt;

    assign index_pos   = POS_W'(cell_index);
    assign index_cnt   = CNT_W'(cell_index);
    assign index_plus1 = index_cnt + CNT_W'(1);

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_HOLD:     data_next = data_reg;
            CELL_SHIFT_IN: data_next = left_data;
            CELL_APPEND: begin
                if (index_cnt == ctrl.count) begin
                    data_next = ctrl.value;
                end
            end
            CELL_REMOVE: begin
                if (index_pos >= ctrl.pos) begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE: begin
                // The occupied part turns by one: the head wraps to the tail.
                if (index_plus1 == ctrl.count) begin
                    data_next = head_data;
                end else if (index_plus1 < ctrl.count) begin
                    data_next = right_data;
                end
            end
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_data = data_reg;

endmodule

[hdl/ordered_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of up to DEPTH signed values kept in a row of cells.
// The block takes an item in ST_IDLE, enters ST_LIST and, once the output
// register is free, loads the first result of the item into it.
// It takes no new item until the last entry of the listing is in the output
// register; the listing rotates the cell row one entry per cycle while the receiver takes every result.
// Reset: synchronous, active low; the list is emptied and no result is held.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [oli_pkg::OP_W-1:0]          s_opcode,
    input  logic signed [oli_pkg::VAL_W-1:0]  s_item_value,
    input  logic [oli_pkg::POS_W-1:0]         s_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [oli_pkg::VAL_W-1:0]  m_entry_value,
    output logic                              m_last_entry,
    output logic                              m_list_empty,
    output logic                              m_insert_dropped
);
    import oli_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         idx_reg;
    logic                     dropped_reg;
    logic                     dropped_next;
    logic                     m_valid_reg;
    logic signed [VAL_W-1:0]  m_value_reg;
    logic                     m_last_reg;
    logic                     m_empty_reg;
    logic                     m_dropped_reg;

    logic        accept;
    logic        load;
    logic        is_last;
    logic        list_full;
    logic        is_insert;
    logic        del_hit;
    cell_ctrl_t  ctrl;

    logic signed [VAL_W-1:0] cell_data [DEPTH];

    // The input side is open whenever no listing is under way; a finished
    // result may still sit in the output register meanwhile.
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign load      = (state_reg == ST_LIST) && (!m_valid_reg || m_ready);
    assign list_full = (count_reg == CNT_W'(DEPTH));
    assign is_insert = (s_opcode == OP_PUSH_FRONT) || (s_opcode == OP_PUSH_BACK);
    // The unused opcode acts as a delete, like the delete code itself.
    assign del_hit   = !is_insert && (s_position < POS_W'(count_reg));
    assign is_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Command for the cell row and the new list length.
    always_comb begin
        ctrl.op      = CELL_HOLD;
        ctrl.value   = s_item_value;
        ctrl.pos     = s_position;
        ctrl.count   = count_reg;
        count_next   = count_reg;
        dropped_next = 1'b0;
        if (accept) begin
            if (is_insert) begin
                if (list_full) begin
                    dropped_next = 1'b1;
                end else begin
                    ctrl.op    = (s_opcode == OP_PUSH_FRONT) ? CELL_SHIFT_IN : CELL_APPEND;
                    count_next = count_reg + CNT_W'(1);
                end
            end else if (del_hit) begin
                ctrl.op    = CELL_REMOVE;
                count_next = count_reg - CNT_W'(1);
            end
        end else if (load && (count_reg != '0)) begin
            // Present the head and turn the list so the next entry comes up.
            ctrl.op = CELL_ROTATE;
        end
    end

    // The row of cells. Cell 0 is the front; the new front value enters from
    // its left, and the last cell sees zero on its right.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [VAL_W-1:0] left_in;
        logic signed [VAL_W-1:0] right_in;

        if (gi == 0) begin : g_first
            assign left_in = s_item_value;
        end else begin : g_inner_l
            assign left_in = cell_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_inner_r
            assign right_in = cell_data[gi+1];
        end

        oli_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(gi)),
            .ctrl       (ctrl),
            .left_data  (left_in),
            .right_data (right_in),
            .head_data  (cell_data[0]),
            .cell_data  (cell_data[gi])
        );
    end

    // Sequencer: takes an operation, then streams the list out through the
    // output register, one entry per free output slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // A taken result frees the output register unless the next
            // entry of the listing moves in at the same edge.
            if (m_valid_reg && m_ready && !load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        count_reg   <= count_next;
                        dropped_reg <= dropped_next;
                        idx_reg     <= '0;
                        state_reg   <= ST_LIST;
                    end
                end
                ST_LIST: begin
                    if (load) begin
                        m_valid_reg   <= 1'b1;
                        m_dropped_reg <= dropped_reg;
                        if (count_reg == '0) begin
                            // An empty list is reported by a single marked item.
                            m_value_reg <= '0;
                            m_last_reg  <= 1'b1;
                            m_empty_reg <= 1'b1;
                            state_reg   <= ST_IDLE;
                        end else begin
                            m_value_reg <= cell_data[0];
                            m_last_reg  <= is_last;
                            m_empty_reg <= 1'b0;
                            idx_reg     <= idx_reg + IDX_W'(1);
                            if (is_last) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_entry_value    = m_value_reg;
    assign m_last_entry     = m_last_reg;
    assign m_list_empty     = m_empty_reg;
    assign m_insert_dropped = m_dropped_reg;

    // The list never grows past its capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("list length exceeds capacity");

    // An insert into a full list leaves the length unchanged.
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_insert && list_full |=> count_reg == CNT_W'(DEPTH) && dropped_reg)
        else $error("insert into full list changed the list");

    // An empty-list item is always the last item of its listing.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_list_empty |-> m_last_entry)
        else $error("empty marker without last marker");

    // While listing a non-empty list the entry index stays inside the list.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LIST && count_reg != '0 |-> CNT_W'(idx_reg) < count_reg)
        else $error("listing index out of range");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered list block. A driver feeds list
// operations from a queue of pending items and a monitor compares every
// listing entry with the entries a behavioral list predicts.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import oli_pkg::*;

    // The spare opcode value. The block treats it as a delete at position.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // The run is stopped here. A correct run sends 210 items of at most 16
    // results each, with a hold on the result side and about a quarter of
    // all cycles idle.
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 26;
    localparam int RANDOM_OPS  = 185;

    typedef struct {
        logic [OP_W-1:0]          opcode;
        logic signed [VAL_W-1:0]  value;
        logic [POS_W-1:0]         position;
        bit                       drain_first;
    } list_op_t;

    typedef struct {
        logic signed [VAL_W-1:0]  entry;
        logic                     last_flag;
        logic                     empty_flag;
        logic                     dropped_flag;
    } listing_entry_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_opcode = OP_PUSH_FRONT;
    logic signed [VAL_W-1:0]  s_item_value = '0;
    logic [POS_W-1:0]         s_position = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [VAL_W-1:0]  m_entry_value;
    logic                     m_last_entry;
    logic                     m_list_empty;
    logic                     m_insert_dropped;

    // Operations still to be offered, and the listing entries that the
    // accepted operations are expected to produce, oldest first.
    list_op_t                 pending_ops[$];
    listing_entry_t           listing_q[$];

    // The predicted contents of the list, front to back.
    logic signed [VAL_W-1:0]  list_model[$];

    // Length of the list as the stimulus generator sees it, so that most
    // delete positions land inside the list.
    int fill = 0;

    int cycle_cnt = 0;
    int results_seen = 0;
    int items_accepted = 0;
    int errors = 0;
    int dropped_inserts = 0;
    int ignored_deletes = 0;
    int empty_listings = 0;
    int full_listings = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit calm;

    ordered_list_insert_delete dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_item_value     (s_item_value),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_entry_value    (m_entry_value),
        .m_last_entry     (m_last_entry),
        .m_list_empty     (m_list_empty),
        .m_insert_dropped (m_insert_dropped)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // A window of cycles in which neither side idles, so that the block
    // also runs at its full rate for a while.
    assign calm = (cycle_cnt >= 1000) && (cycle_cnt < 1800);

    // Queue one operation and keep the generator's idea of the length.
    task automatic add_op(input logic [OP_W-1:0] opcode,
                          input logic signed [VAL_W-1:0] value,
                          input logic [POS_W-1:0] position,
                          input bit drain_first = 1'b0);
        pending_ops.push_back('{opcode, value, position, drain_first});
        if (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK) begin
            if (fill < DEPTH) fill++;
        end else if (position < fill) begin
            fill--;
        end
    endtask

    // Arbitrary values half of the time, with the extremes and small numbers mixed in.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            4: return $signed(32'($urandom_range(0, 15)));
            default: return $signed($urandom);
        endcase
    endfunction

    // Apply one accepted operation to the predicted list and queue the
    // whole listing that the block must send for it.
    task automatic predict_listing(input logic [OP_W-1:0] opcode,
                                   input logic signed [VAL_W-1:0] value,
                                   input logic [POS_W-1:0] position);
        bit refused;
        refused = 1'b0;
        if (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK) begin
            if (list_model.size() >= DEPTH) begin
                // No room left: the list stays as it is and every entry
                // of the listing carries the dropped flag.
                refused = 1'b1;
                dropped_inserts++;
            end else if (opcode == OP_PUSH_FRONT) begin
                list_model.push_front(value);
            end else begin
                list_model.push_back(value);
            end
        end else if (position < list_model.size()) begin
            // Delete and the spare opcode both close the gap at position.
            list_model.delete(position);
        end else begin
            ignored_deletes++;
        end

        if (list_model.size() == 0) begin
            listing_q.push_back('{32'sd0, 1'b1, 1'b1, refused});
            empty_listings++;
        end else begin
            if (list_model.size() == DEPTH) full_listings++;
            foreach (list_model[i]) begin
                listing_q.push_back('{list_model[i], i == list_model.size() - 1,
                                      1'b0, refused});
            end
        end
    endtask

    task automatic check_field(input string name, input longint expected,
                               input longint actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
                     $realtime, name, results_seen, expected, actual);
            errors++;
        end
    endtask

    // Driver. An item that is accepted at this edge goes to the predictor
    // first. Then the next item is offered, unless the sender idles or the
    // next item asks for every outstanding result to arrive first. s_valid
    // gets at most one assignment per edge and none while an item waits, so a held valid never drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_listing(s_opcode, s_item_value, s_position);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_ops.size() != 0 &&
                    !(pending_ops[0].drain_first && listing_q.size() != 0) &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid      <= 1'b1;
                    s_opcode     <= pending_ops[0].opcode;
                    s_item_value <= pending_ops[0].value;
                    s_position   <= pending_ops[0].position;
                    void'(pending_ops.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side ready. Once a few hundred results have passed, the
    // receiver holds off for a long stretch so that the block backs up
    // and stops taking items while the driver keeps offering them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && results_seen >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor. Every accepted result is matched against the oldest
    // expected listing entry.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (listing_q.size() == 0) begin
                $display("%0t: result with no expected entry: expected none, actual %0d",
                         $realtime, m_entry_value);
                errors++;
            end else begin
                check_field("entry_value", listing_q[0].entry, m_entry_value);
                check_field("last_entry", listing_q[0].last_flag, m_last_entry);
                check_field("list_empty", listing_q[0].empty_flag, m_list_empty);
                check_field("insert_dropped", listing_q[0].dropped_flag,
                            m_insert_dropped);
                void'(listing_q.pop_front());
            end
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, listing_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [OP_W-1:0]  opcode;
        logic [POS_W-1:0] position;
        int               insert_pct;
        int               roll;

        // Directed part. Deletes on an empty list, with both the delete
        // opcode and the spare one, come first.
        add_op(OP_DELETE, 32'sd0, 16'd0);
        add_op(OP_UNUSED, 32'sd0, 16'd0);
        // Value extremes at both ends of the list.
        add_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF, 16'd0);
        add_op(OP_PUSH_BACK, 32'sh8000_0000, 16'd0);
        add_op(OP_PUSH_FRONT, -32'sd1, 16'd0);
        add_op(OP_PUSH_BACK, 32'sd0, 16'd0);
        // Out of range deletes: the largest position, and exactly the length.
        add_op(OP_DELETE, 32'sd0, 16'hFFFF);
        add_op(OP_DELETE, 32'sd0, 16'd4);
        // Fill the list to the brim, then try to insert at either end.
        while (fill < DEPTH) begin
            add_op(fill[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value(), 16'd0);
        end
        add_op(OP_PUSH_FRONT, 32'sh1234_5678, 16'd0);
        add_op(OP_PUSH_BACK, -32'sd77, 16'd0);
        // Remove the last entry, the first, and one in the middle.
        add_op(OP_DELETE, 32'sd0, 16'(DEPTH - 1));
        add_op(OP_DELETE, 32'sd0, 16'd0);
        add_op(OP_UNUSED, 32'sd0, 16'd7);

        // Random part. Stretches that mostly grow, mostly shrink or mix
        // the two, so that the list often runs full and often runs dry.
        // Halfway through, the sender waits for the block to drain.
        insert_pct = 50;
        for (int k = 0; k < RANDOM_OPS; k++) begin
            if (k % 25 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            if ($urandom_range(0, 99) < insert_pct) begin
                opcode = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                // Insert items carry a random position that must not matter.
                add_op(opcode, pick_value(), 16'($urandom), k == 90);
            end else begin
                opcode = ($urandom_range(0, 9) == 0) ? OP_UNUSED : OP_DELETE;
                roll = $urandom_range(0, 99);
                if (fill > 0 && roll < 80)
                    position = 16'($urandom_range(0, fill - 1));
                else if (roll < 90)
                    position = 16'($urandom_range(fill, DEPTH + 2));
                else
                    position = 16'($urandom);
                add_op(opcode, $signed($urandom), position, k == 90);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Every item offered and accepted, every listing received.
        while (pending_ops.size() != 0 || s_valid || listing_q.size() != 0)
            @(posedge aclk);
        // Keep running so that a stray extra result would still be caught.
        repeat (20) @(posedge aclk);

        if (listing_q.size() != 0) begin
            $display("%0t: listing entries left over: expected 0, actual %0d",
                     $realtime, listing_q.size());
            errors++;
        end

        $display("Ran %0d list operations, checked %0d listing entries in %0d cycles.",
                 items_accepted, results_seen, cycle_cnt);
        $display("Saw %0d refused inserts, %0d ignored deletes, %0d empty and %0d full lists.",
                 dropped_inserts, ignored_deletes, empty_listings, full_listings);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/oli_pkg.sv
hdl/oli_cell.sv
hdl/ordered_list_insert_delete.sv
bench/tb.sv
